@@ rtl/spi3_pkg.sv @@
// Shared types and constants for the three-wire register port master.
// No dependencies; imported by every module of the block.
`default_nettype none

package spi3_pkg;

    // Command codes carried in the opcode field
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Address bit that marks a register write
    localparam logic [7:0] WRITE_FLAG = 8'h80;
    // Bit position of the first bit sent or received (MSB first)
    localparam logic [2:0] TOP_BIT    = 3'd7;

    // Transaction phase, one-hot
    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_ADDR  = 5'b00010,
        PH_WDATA = 5'b00100,
        PH_RADDR = 5'b01000,
        PH_RDATA = 5'b10000
    } t_phase;

    // One input word
    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] reg_address;
        logic [7:0] write_data;
        logic       dio_sample;
    } t_item;

    // One result word
    typedef struct packed {
        logic       cs_n;
        logic       sck;
        logic       dio_out;
        logic       dio_oe;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       write_ok;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/spi3_in_stage.sv @@
// Input register stage: captures one input word and holds it until the
// engine consumes it. Depends on spi3_pkg.
`default_nettype none

module spi3_in_stage
    import spi3_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_item i_item,
    input  wire logic  i_advance,
    output logic       o_stall,
    output logic       o_valid,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;
    logic  w_load;

    // Take a new word when empty or when the held word moves on
    assign w_load  = !r_valid || i_advance;
    assign o_stall = !w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_valid;
        end
    end

    // Hold payload until it is consumed
    always_ff @(posedge i_clk) begin
        if (w_load && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

@@ rtl/spi3_engine.sv @@
// Transaction state and next-state logic: one input word updates the bus
// levels and the shift registers and yields one result word. Depends on spi3_pkg.
`default_nettype none

module spi3_engine
    import spi3_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_fire,
    input  wire t_item i_item,
    output t_result    o_result
);

    t_phase     r_phase,     n_phase;
    logic [2:0] r_bit_index, n_bit_index;
    logic       r_high_half, n_high_half;
    logic [7:0] r_out_shift, n_out_shift;
    logic [7:0] r_in_shift,  n_in_shift;
    logic       r_is_write,  n_is_write;
    logic [7:0] r_held_addr, n_held_addr;
    logic [7:0] r_held_data, n_held_data;
    logic       r_select,    n_select;
    logic       r_clock,     n_clock;
    logic       r_drive,     n_drive;
    logic       r_data_lvl,  n_data_lvl;

    logic w_active;
    logic w_start;
    logic w_done;

    assign w_active = (r_phase != PH_IDLE);
    assign w_start  = !w_active &&
                      (i_item.opcode == OP_READ || i_item.opcode == OP_WRITE);

    // Compute next state for the word being consumed
    always_comb begin
        n_phase     = r_phase;
        n_bit_index = r_bit_index;
        n_high_half = r_high_half;
        n_out_shift = r_out_shift;
        n_in_shift  = r_in_shift;
        n_is_write  = r_is_write;
        n_held_addr = r_held_addr;
        n_held_data = r_held_data;
        n_select    = r_select;
        n_clock     = r_clock;
        n_drive     = r_drive;
        n_data_lvl  = r_data_lvl;
        w_done      = 1'b0;

        if (w_start) begin
            // Set up a transaction; clock stays high, first tick is a low half
            n_is_write  = (i_item.opcode == OP_WRITE);
            n_held_addr = i_item.reg_address;
            n_held_data = i_item.write_data;
            n_in_shift  = '0;
            n_select    = 1'b0;
            n_clock     = 1'b1;
            n_drive     = 1'b1;
            n_data_lvl  = 1'b0;
            n_phase     = PH_ADDR;
            n_out_shift = (i_item.opcode == OP_WRITE) ?
                          (i_item.reg_address | WRITE_FLAG) : i_item.reg_address;
            n_bit_index = TOP_BIT;
            n_high_half = 1'b0;
        end else if (w_active) begin
            if (!r_high_half) begin
                // Low half: drop the clock, drive or sample a bit
                n_clock = 1'b0;
                if (r_phase == PH_RDATA) begin
                    n_in_shift = {r_in_shift[6:0], i_item.dio_sample};
                end else begin
                    n_data_lvl = r_out_shift[r_bit_index];
                end
                n_high_half = 1'b1;
            end else begin
                // High half: raise the clock, advance bit or phase
                n_clock     = 1'b1;
                n_high_half = 1'b0;
                if (r_bit_index != 3'd0) begin
                    n_bit_index = r_bit_index - 3'd1;
                end else begin
                    n_bit_index = TOP_BIT;
                    unique case (r_phase)
                        PH_ADDR: begin
                            if (r_is_write) begin
                                n_phase     = PH_WDATA;
                                n_out_shift = r_held_data;
                            end else begin
                                n_phase     = PH_RDATA;
                                n_out_shift = '0;
                                n_drive     = 1'b0;
                                n_data_lvl  = 1'b0;
                            end
                        end
                        PH_WDATA: begin
                            n_phase     = PH_RADDR;
                            n_out_shift = r_held_addr;
                        end
                        PH_RADDR: begin
                            n_phase     = PH_RDATA;
                            n_out_shift = '0;
                            n_drive     = 1'b0;
                            n_data_lvl  = 1'b0;
                        end
                        default: begin
                            n_phase    = PH_IDLE;
                            n_select   = 1'b1;
                            n_drive    = 1'b0;
                            n_data_lvl = 1'b0;
                            w_done     = 1'b1;
                        end
                    endcase
                end
            end
        end
    end

    // Advance state on each consumed word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit_index <= TOP_BIT;
            r_high_half <= 1'b0;
            r_out_shift <= '0;
            r_in_shift  <= '0;
            r_is_write  <= 1'b0;
            r_held_addr <= '0;
            r_held_data <= '0;
            r_select    <= 1'b1;
            r_clock     <= 1'b1;
            r_drive     <= 1'b0;
            r_data_lvl  <= 1'b0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_bit_index <= n_bit_index;
            r_high_half <= n_high_half;
            r_out_shift <= n_out_shift;
            r_in_shift  <= n_in_shift;
            r_is_write  <= n_is_write;
            r_held_addr <= n_held_addr;
            r_held_data <= n_held_data;
            r_select    <= n_select;
            r_clock     <= n_clock;
            r_drive     <= n_drive;
            r_data_lvl  <= n_data_lvl;
        end
    end

    // Result word reflects the levels after this word
    always_comb begin
        o_result.cs_n      = n_select;
        o_result.sck       = n_clock;
        o_result.dio_out   = n_drive & n_data_lvl;
        o_result.dio_oe    = n_drive;
        o_result.busy_res  = (n_phase != PH_IDLE);
        o_result.done_res  = w_done;
        o_result.read_data = w_done ? n_in_shift : 8'd0;
        o_result.write_ok  = w_done && r_is_write && (n_in_shift == r_held_data);
    end

endmodule

`default_nettype wire

@@ rtl/spi3_out_stage.sv @@
// Result register stage: holds one result word until the receiver takes it.
// Depends on spi3_pkg.
`default_nettype none

module spi3_out_stage
    import spi3_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_result i_result,
    input  wire logic    i_stall,
    output logic         o_ready,
    output logic         o_valid,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_result;

    // Free when empty or when the held word is taken this cycle
    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Hold result while stalled
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

@@ rtl/three_wire_spi_register_master_top.sv @@
// Three-wire half-duplex register port master, top level.
// Path: an accepted word is held in the input register, then passes through the engine into the result register.
// Throughput: one word per cycle while the receiver does not stall the result register.
// Reset: synchronous, active low; engine returns to idle with chip select and clock
// high, and both word registers are empty.
// Uses spi3_pkg, spi3_in_stage, spi3_engine and spi3_out_stage.
`default_nettype none

module three_wire_spi_register_master_top
    import spi3_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [1:0] i_opcode,
    input  wire logic [7:0] i_reg_address,
    input  wire logic [7:0] i_write_data,
    input  wire logic       i_dio_sample,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_cs_n,
    output logic            o_sck,
    output logic            o_dio_out,
    output logic            o_dio_oe,
    output logic            o_busy_res,
    output logic            o_done_res,
    output logic [7:0]      o_read_data,
    output logic            o_write_ok
);

    t_item   w_in_item;
    t_item   w_held_item;
    logic    w_held_valid;
    logic    w_out_ready;
    logic    w_advance;
    t_result w_next_result;
    t_result w_result;

    assign w_in_item.opcode      = i_opcode;
    assign w_in_item.reg_address = i_reg_address;
    assign w_in_item.write_data  = i_write_data;
    assign w_in_item.dio_sample  = i_dio_sample;

    // Move a word from input register to result register
    assign w_advance = w_held_valid && w_out_ready;

    spi3_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_item    (w_in_item),
        .i_advance (w_advance),
        .o_stall   (o_in_stall),
        .o_valid   (w_held_valid),
        .o_item    (w_held_item)
    );

    spi3_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_advance),
        .i_item   (w_held_item),
        .o_result (w_next_result)
    );

    spi3_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_held_valid),
        .i_result (w_next_result),
        .i_stall  (i_out_stall),
        .o_ready  (w_out_ready),
        .o_valid  (o_out_valid),
        .o_result (w_result)
    );

    assign o_cs_n      = w_result.cs_n;
    assign o_sck       = w_result.sck;
    assign o_dio_out   = w_result.dio_out;
    assign o_dio_oe    = w_result.dio_oe;
    assign o_busy_res  = w_result.busy_res;
    assign o_done_res  = w_result.done_res;
    assign o_read_data = w_result.read_data;
    assign o_write_ok  = w_result.write_ok;

endmodule

`default_nettype wire
